/* rtl/lts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_pkg: lap timer statistics package
// event kinds, status codes, sequencer states and shared constants
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int DATA_W      = 32;
	localparam int KIND_W      = 3;
	localparam int RANK_W      = 3;
	localparam int STATUS_W    = 2;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 296;
	localparam int M_TDATA_PAD = M_TDATA_W - (STATUS_W + 9 * DATA_W + 2);
	localparam int S_TDATA_PAD = S_TDATA_W - (DATA_W + RANK_W);

	localparam logic [DATA_W-1:0] MIN_LAP_RESET = 32'h0000_7fff;
	localparam logic [DATA_W-1:0] CUTOFF_RESET  = 32'd60;

	typedef enum logic [KIND_W-1:0] {
		KIND_START  = 3'd0,
		KIND_STOP   = 3'd1,
		KIND_PAUSE  = 3'd2,
		KIND_RESUME = 3'd3,
		KIND_LAP    = 3'd4,
		KIND_CLEAR  = 3'd5
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_INACTIVE = 2'd1,
		STATUS_PAUSED   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_CALC  = 2'd1,
		ST_APPLY = 2'd2,
		ST_OUT   = 2'd3
	} seq_state_t;

	typedef struct packed {
		logic              clr;
		logic              upd;
		logic [DATA_W-1:0] t;
	} worst_ctrl_t;

endpackage

/* rtl/lts_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_cell: one entry of the worst-lap list
// compares the new lap with its entry and takes the new lap or its
// neighbor's entry when the list shifts down
// ----------------------------------------------------------------------------
module lts_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clr,
	input  logic                      ins,
	input  logic [lts_pkg::DATA_W-1:0] t,
	input  logic [lts_pkg::DATA_W-1:0] prev_val,
	input  logic                      prev_ge,
	output logic [lts_pkg::DATA_W-1:0] val,
	output logic                      ge
);
	import lts_pkg::*;

	logic [DATA_W-1:0] val_q;

	assign ge  = (t >= val_q);
	assign val = val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (clr) begin
			val_q <= '0;
		end else if (ins && ge) begin
			val_q <= prev_ge ? prev_val : t;
		end
	end

endmodule

/* rtl/lts_worst_row.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lts_worst_row: descending list of the longest laps
// a row of compare-and-shift cells plus the rank read mux
// ----------------------------------------------------------------------------
module lts_worst_row #(
	parameter int WORST_DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lts_pkg::worst_ctrl_t       ctrl,
	input  logic [lts_pkg::RANK_W-1:0] rank,
	output logic [lts_pkg::DATA_W-1:0] worst_value
);
	import lts_pkg::*;

	localparam int READ_SPAN = (WORST_DEPTH < (1 << RANK_W)) ? WORST_DEPTH : (1 << RANK_W);

	logic [DATA_W-1:0] val [WORST_DEPTH];
	logic              ge  [WORST_DEPTH];
	logic              ins;

	assign ins = ctrl.upd && (ctrl.t > val[WORST_DEPTH-1]);

	for (genvar i = 0; i < WORST_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			lts_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clr      (ctrl.clr),
				.ins      (ins),
				.t        (ctrl.t),
				.prev_val ('0),
				.prev_ge  (1'b0),
				.val      (val[i]),
				.ge       (ge[i])
			);
		end else begin : g_body
			lts_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clr      (ctrl.clr),
				.ins      (ins),
				.t        (ctrl.t),
				.prev_val (val[i-1]),
				.prev_ge  (ge[i-1]),
				.val      (val[i]),
				.ge       (ge[i])
			);
		end
	end

	always_comb begin
		worst_value = '0;
		for (int i = 0; i < READ_SPAN; i++) begin
			if (rank == RANK_W'(i)) begin
				worst_value = val[i];
			end
		end
	end

	// list order
	for (genvar i = 1; i < WORST_DEPTH; i++) begin : g_order_chk
		a_descending: assert property (@(posedge clk) disable iff (!arst_n)
			val[i-1] >= val[i])
			else $error("worst list out of order");
	end

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clr |=> (val[0] == '0))
		else $error("worst list head not cleared");

	a_new_head: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.upd && !ctrl.clr && (ctrl.t > val[0])) |=> (val[0] == $past(ctrl.t)))
		else $error("longest lap not at head");

endmodule

/* rtl/lap_timer_statistics_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lap_timer_statistics_unit: profiling lap timer with worst-lap list
// keeps lap statistics from start/stop/pause/resume/lap/clear events
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  tuser kind, tdata now and worst_index
// m_*       out        m_tvalid/m_tready  tdata status and statistics snapshot
// cfg_*     in         cfg_we             cfg_wdata big-lap cutoff
//
// an item passes through accept, lap/pause arithmetic, state and list
// update and result load; the sequencer holds one item at a time
// the next item is accepted while the previous result waits in m_tdata
// a stalled result holds the sequencer in its load step
// reset clears the statistics (shortest lap to 0x7fff), empties the list and sets the cutoff to 60
// ----------------------------------------------------------------------------
module lap_timer_statistics_unit #(
	parameter int WORST_DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// now, worst_index
	input  logic [lts_pkg::S_TDATA_W-1:0] s_tdata,
	// kind
	input  logic [lts_pkg::KIND_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, lap_time, min_lap, max_lap, lap_count, big_lap_count,
	// big_lap_total, pause_total, total_time, is_active, is_paused, worst_value
	output logic [lts_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                          cfg_we,
	input  logic [lts_pkg::DATA_W-1:0]    cfg_wdata
);
	import lts_pkg::*;

	seq_state_t state_q, state_d;
	logic calc_en, apply_en, out_load;

	logic [KIND_W-1:0] kind_s1;
	logic [DATA_W-1:0] now_s1;
	logic [RANK_W-1:0] rank_s1;
	kind_t             kind_c;

	logic [DATA_W-1:0] lap_time_s2, pause_delta_s2;
	status_t           status_s2;
	logic [DATA_W-1:0] lap_res_s3;
	status_t           status_s3;
	logic              lap_ok;

	logic [DATA_W-1:0] cutoff_q;
	logic [DATA_W-1:0] start_time_q, lap_start_q, pause_sum_q, lap_pause_sum_q;
	logic [DATA_W-1:0] pause_began_q, shortest_q, longest_q, big_sum_q;
	logic [DATA_W-1:0] laps_done_q, big_laps_q;
	logic              running_q, held_q;

	logic              m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [DATA_W-1:0] worst_rd;
	logic [DATA_W-1:0] total_time;
	worst_ctrl_t       wctrl;

	assign kind_c = kind_t'(kind_s1);
	assign lap_ok = (kind_c == KIND_LAP) && (status_s2 == STATUS_OK);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_CALC;
			ST_CALC:  state_d = ST_APPLY;
			ST_APPLY: state_d = ST_OUT;
			ST_OUT:   if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		calc_en  = 1'b0;
		apply_en = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_CALC:  calc_en  = 1'b1;
			ST_APPLY: apply_en = 1'b1;
			ST_OUT:   out_load = !m_tvalid_q || m_tready;
			default:  s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= CUTOFF_RESET;
		end else if (cfg_we) begin
			cutoff_q <= cfg_wdata;
		end
	end

	// item capture and arithmetic
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			now_s1  <= s_tdata[DATA_W-1:0];
			rank_s1 <= s_tdata[DATA_W +: RANK_W];
		end
		if (calc_en) begin
			lap_time_s2    <= (now_s1 - lap_start_q) - lap_pause_sum_q;
			pause_delta_s2 <= now_s1 - pause_began_q;
			if (kind_c == KIND_LAP && !running_q) begin
				status_s2 <= STATUS_INACTIVE;
			end else if (kind_c == KIND_LAP && held_q) begin
				status_s2 <= STATUS_PAUSED;
			end else begin
				status_s2 <= STATUS_OK;
			end
		end
		if (apply_en) begin
			status_s3  <= status_s2;
			lap_res_s3 <= lap_ok ? lap_time_s2 : '0;
		end
	end

	// statistics state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q    <= '0;
			lap_start_q     <= '0;
			pause_sum_q     <= '0;
			lap_pause_sum_q <= '0;
			pause_began_q   <= '0;
			shortest_q      <= MIN_LAP_RESET;
			longest_q       <= '0;
			big_sum_q       <= '0;
			laps_done_q     <= '0;
			big_laps_q      <= '0;
			running_q       <= 1'b0;
			held_q          <= 1'b0;
		end else if (apply_en) begin
			case (kind_c) inside
				KIND_START, KIND_CLEAR: begin
					pause_sum_q     <= '0;
					lap_pause_sum_q <= '0;
					pause_began_q   <= '0;
					shortest_q      <= MIN_LAP_RESET;
					longest_q       <= '0;
					big_sum_q       <= '0;
					laps_done_q     <= '0;
					big_laps_q      <= '0;
					held_q          <= 1'b0;
					if (kind_c == KIND_START) begin
						start_time_q <= now_s1;
						lap_start_q  <= now_s1;
						running_q    <= 1'b1;
					end else begin
						start_time_q <= '0;
						lap_start_q  <= '0;
						running_q    <= 1'b0;
					end
				end
				KIND_STOP: begin
					if (running_q) begin
						running_q <= 1'b0;
						if (held_q) begin
							lap_pause_sum_q <= lap_pause_sum_q + pause_delta_s2;
							held_q          <= 1'b0;
						end
					end
				end
				KIND_PAUSE: begin
					if (!held_q) begin
						pause_began_q <= now_s1;
						held_q        <= 1'b1;
					end
				end
				KIND_RESUME: begin
					if (held_q) begin
						lap_pause_sum_q <= lap_pause_sum_q + pause_delta_s2;
						held_q          <= 1'b0;
					end
				end
				KIND_LAP: begin
					if (lap_ok) begin
						laps_done_q     <= laps_done_q + 1'b1;
						pause_sum_q     <= pause_sum_q + lap_pause_sum_q;
						lap_pause_sum_q <= '0;
						lap_start_q     <= now_s1;
						if (start_time_q == lap_start_q) begin
							shortest_q <= lap_time_s2;
							longest_q  <= lap_time_s2;
						end else begin
							if (lap_time_s2 < shortest_q) shortest_q <= lap_time_s2;
							if (lap_time_s2 > longest_q) longest_q <= lap_time_s2;
						end
						if (lap_time_s2 >= cutoff_q) begin
							big_sum_q  <= big_sum_q + lap_time_s2;
							big_laps_q <= big_laps_q + 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// worst-lap list
	assign wctrl.clr = apply_en && (kind_c == KIND_START || kind_c == KIND_CLEAR);
	assign wctrl.upd = apply_en && lap_ok;
	assign wctrl.t   = lap_time_s2;

	lts_worst_row #(
		.WORST_DEPTH (WORST_DEPTH)
	) u_worst_row (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (wctrl),
		.rank        (rank_s1),
		.worst_value (worst_rd)
	);

	// result register
	assign total_time = lap_start_q - start_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {{M_TDATA_PAD{1'b0}}, worst_rd, held_q, running_q, total_time,
				pause_sum_q, big_sum_q, big_laps_q, laps_done_q, longest_q, shortest_q,
				lap_res_s3, status_s3};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(apply_en && kind_c == KIND_START) |=> (running_q && !held_q))
		else $error("start did not leave timer running");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (status_s3 == STATUS_OK || lap_res_s3 == '0))
		else $error("refused lap carries a lap time");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && m_tvalid_q && !m_tready) |=> (state_q == ST_OUT))
		else $error("result step left while output stalled");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: lap timer statistics unit
// drives timer events over the input stream, predicts the statistics
// snapshot of every event and checks each result item field by field
// ----------------------------------------------------------------------------
module testbench;
	import lts_pkg::*;

	localparam int WORST_DEPTH     = 8;
	localparam int PHASE_COUNT     = 6;
	localparam int PHASE_ITEMS     = 215;
	localparam int PRESSURE_PHASE  = 4;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STUCK_LIMIT     = 5000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int MAX_REPORTS     = 100;

	// kinds with no defined action
	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] now;
		logic [RANK_W-1:0] rank;
	} timer_event_t;

	typedef struct packed {
		logic [M_TDATA_PAD-1:0] pad;
		logic [DATA_W-1:0]      worst_value;
		logic                   is_paused;
		logic                   is_active;
		logic [DATA_W-1:0]      total_time;
		logic [DATA_W-1:0]      pause_total;
		logic [DATA_W-1:0]      big_lap_total;
		logic [DATA_W-1:0]      big_lap_count;
		logic [DATA_W-1:0]      lap_count;
		logic [DATA_W-1:0]      max_lap;
		logic [DATA_W-1:0]      min_lap;
		logic [DATA_W-1:0]      lap_time;
		logic [STATUS_W-1:0]    status;
	} lap_snapshot_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0]    s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we = 1'b0;
	logic [DATA_W-1:0]    cfg_wdata = '0;

	// predicted timer state
	logic [DATA_W-1:0] cutoff;
	logic [DATA_W-1:0] t_start, t_lap_start, pause_closed, pause_open, pause_mark;
	logic [DATA_W-1:0] lap_min, lap_max, big_time, laps_seen, big_seen;
	logic              active, paused;
	logic [DATA_W-1:0] worst_laps [WORST_DEPTH];

	timer_event_t  pending_events [$];
	lap_snapshot_t expected_snapshots [$];
	timer_event_t  on_bus;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_req = 0;
	int hold_off_ack = 0;
	int hold_left = 0;
	int stuck_cycles = 0;
	int mismatches = 0;

	// event generator shaping state
	logic [DATA_W-1:0] gen_clock = '0;
	logic              gen_running = 1'b0;
	logic              gen_held = 1'b0;

	lap_timer_statistics_unit #(
		.WORST_DEPTH(WORST_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic clear_timer();
		for (int i = 0; i < WORST_DEPTH; i++) begin
			worst_laps[i] = '0;
		end
		t_start = '0;
		t_lap_start = '0;
		pause_closed = '0;
		pause_open = '0;
		pause_mark = '0;
		lap_min = MIN_LAP_RESET;
		lap_max = '0;
		big_time = '0;
		laps_seen = '0;
		big_seen = '0;
		active = 1'b0;
		paused = 1'b0;
	endtask

	task automatic end_pause(input logic [DATA_W-1:0] now);
		if (paused) begin
			pause_open = pause_open + (now - pause_mark);
			paused = 1'b0;
		end
	endtask

	task automatic predict_snapshot(input timer_event_t ev, output lap_snapshot_t snap);
		logic [DATA_W-1:0]   lap_t;
		logic [DATA_W-1:0]   carry;
		logic [DATA_W-1:0]   swap;
		logic [STATUS_W-1:0] code;
		logic                placed;
		lap_t = '0;
		code = STATUS_OK;
		case (ev.kind)
			KIND_START: begin
				clear_timer();
				t_start = ev.now;
				t_lap_start = ev.now;
				active = 1'b1;
			end
			KIND_STOP: begin
				if (active) begin
					active = 1'b0;
					end_pause(ev.now);
				end
			end
			KIND_PAUSE: begin
				if (!paused) begin
					pause_mark = ev.now;
					paused = 1'b1;
				end
			end
			KIND_RESUME: begin
				end_pause(ev.now);
			end
			KIND_LAP: begin
				if (!active) begin
					code = STATUS_INACTIVE;
				end else if (paused) begin
					code = STATUS_PAUSED;
				end else begin
					lap_t = (ev.now - t_lap_start) - pause_open;
					laps_seen = laps_seen + 1;
					pause_closed = pause_closed + pause_open;
					pause_open = '0;
					// first lap after a start seeds both extremes
					if (t_start == t_lap_start) begin
						lap_min = lap_t;
						lap_max = lap_t;
					end else begin
						if (lap_t < lap_min) lap_min = lap_t;
						if (lap_t > lap_max) lap_max = lap_t;
					end
					t_lap_start = ev.now;
					if (lap_t > worst_laps[WORST_DEPTH-1]) begin
						carry = lap_t;
						placed = 1'b0;
						for (int i = 0; i < WORST_DEPTH; i++) begin
							if (!placed && lap_t >= worst_laps[i]) placed = 1'b1;
							if (placed) begin
								swap = worst_laps[i];
								worst_laps[i] = carry;
								carry = swap;
							end
						end
					end
					if (lap_t >= cutoff) begin
						big_time = big_time + lap_t;
						big_seen = big_seen + 1;
					end
				end
			end
			KIND_CLEAR: begin
				clear_timer();
			end
			default: ;
		endcase
		snap = '0;
		snap.status = code;
		snap.lap_time = lap_t;
		snap.min_lap = lap_min;
		snap.max_lap = lap_max;
		snap.lap_count = laps_seen;
		snap.big_lap_count = big_seen;
		snap.big_lap_total = big_time;
		snap.pause_total = pause_closed;
		snap.total_time = t_lap_start - t_start;
		snap.is_active = active;
		snap.is_paused = paused;
		snap.worst_value = (ev.rank < WORST_DEPTH) ? worst_laps[ev.rank] : '0;
	endtask

	function automatic timer_event_t make_event(input logic [KIND_W-1:0] kind,
			input logic [DATA_W-1:0] now, input logic [RANK_W-1:0] rank);
		timer_event_t ev;
		ev.kind = kind;
		ev.now = now;
		ev.rank = rank;
		return ev;
	endfunction

	task automatic next_random_event(output timer_event_t ev);
		int                pick;
		logic [DATA_W-1:0] step;
		pick = $urandom_range(0, 99);
		if (!gen_running) begin
			ev.kind = (pick < 65) ? KIND_START : KIND_W'($urandom_range(0, 7));
		end else if (gen_held) begin
			if (pick < 55) ev.kind = KIND_RESUME;
			else if (pick < 75) ev.kind = KIND_LAP;
			else if (pick < 78) ev.kind = KIND_STOP;
			else ev.kind = KIND_W'($urandom_range(0, 7));
		end else begin
			if (pick < 58) ev.kind = KIND_LAP;
			else if (pick < 70) ev.kind = KIND_PAUSE;
			else if (pick < 74) ev.kind = KIND_RESUME;
			else if (pick < 76) ev.kind = KIND_STOP;
			else if (pick < 78) ev.kind = KIND_START;
			else if (pick < 79) ev.kind = KIND_CLEAR;
			else if (pick < 81) ev.kind = (pick < 80) ? KIND_SPARE_A : KIND_SPARE_B;
			else if (pick < 85) ev.kind = KIND_W'($urandom_range(0, 7));
			else ev.kind = KIND_LAP;
		end
		pick = $urandom_range(0, 99);
		if (pick < 70) step = $urandom_range(0, 120);
		else if (pick < 90) step = $urandom_range(0, 5000);
		else step = $urandom;
		gen_clock = gen_clock + step;
		// a few timestamps out of order
		ev.now = ($urandom_range(0, 99) < 3) ? DATA_W'($urandom) : gen_clock;
		ev.rank = RANK_W'($urandom_range(0, WORST_DEPTH - 1));
		case (ev.kind)
			KIND_START: begin
				gen_running = 1'b1;
				gen_held = 1'b0;
			end
			KIND_STOP: begin
				gen_running = 1'b0;
				gen_held = 1'b0;
			end
			KIND_PAUSE: gen_held = 1'b1;
			KIND_RESUME: gen_held = 1'b0;
			KIND_CLEAR: begin
				gen_running = 1'b0;
				gen_held = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic write_cutoff(input logic [DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		cutoff = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_until_drained();
		while (pending_events.size() != 0 || s_tvalid || expected_snapshots.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			if (mismatches < MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			end
			mismatches++;
		end
	endtask

	// input driver
	always @(posedge clk) begin : event_driver
		lap_snapshot_t snap;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_snapshot(on_bus, snap);
				expected_snapshots.push_back(snap);
			end
			if (!s_tvalid || s_tready) begin
				if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					on_bus = pending_events.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{S_TDATA_PAD{1'b0}}, on_bus.rank, on_bus.now};
					s_tuser <= on_bus.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output ready with random stalls and one long hold-off
	always @(posedge clk) begin
		if (hold_off_ack != hold_off_req) begin
			hold_off_ack <= hold_off_req;
			hold_left <= HOLD_OFF_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin : result_monitor
		lap_snapshot_t got;
		lap_snapshot_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_snapshots.size() == 0) begin
				if (mismatches < MAX_REPORTS) begin
					$display("%0t: unexpected result item, expected none, got %h", $time, m_tdata);
				end
				mismatches++;
			end else begin
				want = expected_snapshots.pop_front();
				check_field("status", DATA_W'(want.status), DATA_W'(got.status));
				check_field("lap_time", want.lap_time, got.lap_time);
				check_field("min_lap", want.min_lap, got.min_lap);
				check_field("max_lap", want.max_lap, got.max_lap);
				check_field("lap_count", want.lap_count, got.lap_count);
				check_field("big_lap_count", want.big_lap_count, got.big_lap_count);
				check_field("big_lap_total", want.big_lap_total, got.big_lap_total);
				check_field("pause_total", want.pause_total, got.pause_total);
				check_field("total_time", want.total_time, got.total_time);
				check_field("is_active", DATA_W'(want.is_active), DATA_W'(got.is_active));
				check_field("is_paused", DATA_W'(want.is_paused), DATA_W'(got.is_paused));
				check_field("worst_value", want.worst_value, got.worst_value);
			end
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		timer_event_t      ev;
		logic [DATA_W-1:0] new_cutoff;
		clear_timer();
		cutoff = CUTOFF_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// pause and lap while inactive, wrap of the lap time, refused laps
		pending_events.push_back(make_event(KIND_PAUSE, 32'h0000_000a, 0));
		pending_events.push_back(make_event(KIND_LAP, 32'h0000_000f, 1));
		pending_events.push_back(make_event(KIND_RESUME, 32'h0000_0014, 2));
		pending_events.push_back(make_event(KIND_START, 32'hffff_fff0, 3));
		pending_events.push_back(make_event(KIND_LAP, 32'h0000_0010, 0));
		pending_events.push_back(make_event(KIND_PAUSE, 32'h0000_0020, 1));
		pending_events.push_back(make_event(KIND_LAP, 32'h0000_0030, 2));
		pending_events.push_back(make_event(KIND_PAUSE, 32'h0000_0040, 3));
		pending_events.push_back(make_event(KIND_RESUME, 32'h0000_0050, 4));
		pending_events.push_back(make_event(KIND_LAP, 32'h0000_0100, 0));
		pending_events.push_back(make_event(KIND_LAP, 32'h0000_0100, 1));
		pending_events.push_back(make_event(KIND_LAP, 32'hffff_ffff, 2));
		pending_events.push_back(make_event(KIND_PAUSE, 32'h0000_0010, 5));
		// stop while paused closes the pause
		pending_events.push_back(make_event(KIND_STOP, 32'h0000_1000, 6));
		pending_events.push_back(make_event(KIND_LAP, 32'h0000_2000, 7));
		pending_events.push_back(make_event(KIND_RESUME, 32'h0000_3000, 0));
		pending_events.push_back(make_event(KIND_SPARE_A, 32'h7fff_ffff, 1));
		pending_events.push_back(make_event(KIND_SPARE_B, 32'h8000_0000, 2));
		pending_events.push_back(make_event(KIND_START, 32'h0000_0000, 3));
		pending_events.push_back(make_event(KIND_START, 32'h0000_0064, 4));
		pending_events.push_back(make_event(KIND_LAP, 32'h0000_0096, 0));
		pending_events.push_back(make_event(KIND_LAP, 32'h0000_00a0, 1));
		pending_events.push_back(make_event(KIND_LAP, 32'h0000_0190, 1));
		pending_events.push_back(make_event(KIND_LAP, 32'h0000_0191, 2));
		pending_events.push_back(make_event(KIND_CLEAR, 32'hffff_ffff, 7));
		wait_until_drained();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin
					new_cutoff = '0;
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					new_cutoff = 32'd100;
					send_idle_pct = 86;
					recv_stall_pct = 0;
				end
				2: begin
					new_cutoff = '1;
					send_idle_pct = 0;
					recv_stall_pct = 86;
				end
				3: begin
					new_cutoff = $urandom;
					send_idle_pct = 23;
					recv_stall_pct = 23;
				end
				4: begin
					new_cutoff = 32'd40;
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				default: begin
					new_cutoff = $urandom_range(0, 300);
					send_idle_pct = 23;
					recv_stall_pct = 23;
				end
			endcase
			write_cutoff(new_cutoff);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				next_random_event(ev);
				pending_events.push_back(ev);
			end
			if (p == PRESSURE_PHASE) hold_off_req++;
			wait_until_drained();
		end

		if (mismatches == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
